// ===== design/gea_pkg.sv =====
// Shared constants, types and angle helpers for the gimbal angle estimator.
// No dependencies; every other file refers to it by scoped names.
package gea_pkg;

	// Fixed point of the gyro integral
	localparam int FRACTION_BITS = 16;

	// Field widths
	localparam int RATE_W   = 18;
	localparam int ANGLE_W  = 15;
	localparam int DIV_W    = 14;
	localparam int THR_W    = 17;
	localparam int COUNT_W  = 16;

	// Integral and quotient widths
	localparam int INT_W    = ANGLE_W + FRACTION_BITS;
	localparam int QUOT_W   = RATE_W + FRACTION_BITS;
	localparam int STEP_W   = $clog2(QUOT_W + 1);

	// One full turn in 1/64 degree, and the integral modulus
	localparam logic [ANGLE_W-1:0] FULL_TURN   = 15'd23040;
	localparam logic [INT_W-1:0]   INT_MODULUS = {FULL_TURN, {FRACTION_BITS{1'b0}}};

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_DIVIDER    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STILL_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS    = 2'd2;

	localparam logic [DIV_W-1:0]   RST_RATE_DIVIDER    = 14'd1000;
	localparam logic [THR_W-1:0]   RST_STILL_THRESHOLD = 17'd192;
	localparam logic [COUNT_W-1:0] RST_SETTLE_TICKS    = 16'd400;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Source tracker request
	typedef struct packed {
		logic update;
		logic use_enc;
		logic force_enc;
	} src_req_t;

	// (a + b) mod FULL_TURN, both operands in range
	function automatic logic [ANGLE_W-1:0] wrap_add(input logic [ANGLE_W-1:0] a,
			input logic [ANGLE_W-1:0] b);
		logic [ANGLE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, FULL_TURN}) begin
			s = s - {1'b0, FULL_TURN};
		end
		return s[ANGLE_W-1:0];
	endfunction

	// (a - b) mod FULL_TURN, both operands in range
	function automatic logic [ANGLE_W-1:0] wrap_sub(input logic [ANGLE_W-1:0] a,
			input logic [ANGLE_W-1:0] b);
		logic [ANGLE_W:0] s;
		if (a >= b) begin
			s = {1'b0, a} - {1'b0, b};
		end else begin
			s = {1'b0, a} + {1'b0, FULL_TURN} - {1'b0, b};
		end
		return s[ANGLE_W-1:0];
	endfunction

endpackage

// ===== design/gea_in_if.sv =====
// Input channel of the angle estimator: one sensor sample per beat.
// Depends on gea_pkg for field widths.
interface gea_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [gea_pkg::RATE_W-1:0] pitch_rate;
	logic [gea_pkg::ANGLE_W-1:0]       encoder_angle;
	logic signed [gea_pkg::RATE_W-1:0] chassis_rate;
	logic                              force_encoder;

	modport source(output valid, pitch_rate, encoder_angle, chassis_rate, force_encoder,
		input ready);
	modport sink(input valid, pitch_rate, encoder_angle, chassis_rate, force_encoder,
		output ready);
endinterface

// ===== design/gea_out_if.sv =====
// Result channel of the angle estimator: one angle estimate per beat.
// Depends on gea_pkg for field widths.
interface gea_out_if;
	logic                        valid;
	logic                        ready;
	logic [gea_pkg::ANGLE_W-1:0] angle_out;
	logic                        encoder_used;

	modport source(output valid, angle_out, encoder_used, input ready);
	modport sink(input valid, angle_out, encoder_used, output ready);
endinterface

// ===== design/gea_cfg_if.sv =====
// Configuration write channel: register index and write data per beat.
// Depends on gea_pkg for index and data widths.
interface gea_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [gea_pkg::CFG_IDX_W-1:0]  index;
	logic [gea_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== design/gea_div.sv =====
// Bit-serial restoring divider: (mag << FRACTION_BITS) / divisor, one quotient
// bit per cycle, with the quotient reduced modulo the integral modulus on the fly.
// Depends on gea_pkg.
module gea_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [gea_pkg::RATE_W-1:0]   mag,
	input  logic [gea_pkg::DIV_W-1:0]    divisor,
	output gea_pkg::div_stat_t           stat,
	output logic [gea_pkg::INT_W-1:0]    qmod
);

	logic                                 busy_q;
	logic                                 done_q;
	logic [gea_pkg::STEP_W-1:0]           step_q;
	logic [gea_pkg::RATE_W-1:0]           dvd_q;
	logic [gea_pkg::DIV_W-1:0]            dvs_q;
	logic [gea_pkg::DIV_W-1:0]            rem_q;
	logic [gea_pkg::ANGLE_W-1:0]          qhi_q;
	logic [gea_pkg::FRACTION_BITS-1:0]    qlo_q;

	logic [gea_pkg::DIV_W:0]              rem_sh;
	logic                                 qbit;
	logic [gea_pkg::DIV_W:0]              rem_nx;
	logic [gea_pkg::ANGLE_W:0]            qhi_sh;
	logic [gea_pkg::ANGLE_W:0]            qhi_nx;
	logic                                 hi_phase;
	logic                                 last_step;

	// One restoring step: shift in the next dividend bit, trial subtract
	always_comb begin
		rem_sh = {rem_q, dvd_q[gea_pkg::RATE_W-1]};
		qbit   = rem_sh >= {1'b0, dvs_q};
		rem_nx = qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	// Fold the upper quotient bits into a residue below one full turn
	always_comb begin
		qhi_sh = {qhi_q, qbit};
		qhi_nx = (qhi_sh >= {1'b0, gea_pkg::FULL_TURN}) ?
			(qhi_sh - {1'b0, gea_pkg::FULL_TURN}) : qhi_sh;
	end

	assign hi_phase  = step_q < gea_pkg::STEP_W'(gea_pkg::RATE_W);
	assign last_step = step_q == gea_pkg::STEP_W'(gea_pkg::QUOT_W - 1);

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Advance the datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= mag;
			dvs_q <= (divisor == '0) ? gea_pkg::DIV_W'(1) : divisor;
			rem_q <= '0;
			qhi_q <= '0;
			qlo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[gea_pkg::RATE_W-2:0], 1'b0};
			rem_q <= rem_nx[gea_pkg::DIV_W-1:0];
			if (hi_phase) begin
				qhi_q <= qhi_nx[gea_pkg::ANGLE_W-1:0];
			end else begin
				qlo_q <= {qlo_q[gea_pkg::FRACTION_BITS-2:0], qbit};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign qmod      = {qhi_q, qlo_q};

endmodule

// ===== design/gea_src.sv =====
// Source tracker: chooses encoder or gyro angle, recaptures offsets on a source
// change and holds the output angle. Depends on gea_pkg.
module gea_src (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gea_pkg::src_req_t             req,
	input  logic [gea_pkg::ANGLE_W-1:0]   enc,
	input  logic [gea_pkg::ANGLE_W-1:0]   gyro,
	output logic [gea_pkg::ANGLE_W-1:0]   angle,
	output logic                          from_enc
);

	logic                        src_enc_q;
	logic [gea_pkg::ANGLE_W-1:0] enc_off_q;
	logic [gea_pkg::ANGLE_W-1:0] gyro_off_q;
	logic [gea_pkg::ANGLE_W-1:0] angle_q;

	logic [gea_pkg::ANGLE_W-1:0] enc_off_nx;
	logic [gea_pkg::ANGLE_W-1:0] gyro_off_nx;
	logic [gea_pkg::ANGLE_W-1:0] angle_nx;

	// Recapture the offset of the source taking over (zero for a forced encoder), then add it in
	always_comb begin
		enc_off_nx  = enc_off_q;
		gyro_off_nx = gyro_off_q;
		if (req.use_enc) begin
			if (!src_enc_q) begin
				enc_off_nx = gea_pkg::wrap_sub(angle_q, enc);
			end
			if (req.force_enc) begin
				enc_off_nx = '0;
			end
			angle_nx = gea_pkg::wrap_add(enc, enc_off_nx);
		end else begin
			if (src_enc_q) begin
				gyro_off_nx = gea_pkg::wrap_sub(angle_q, gyro);
			end
			angle_nx = gea_pkg::wrap_add(gyro, gyro_off_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_enc_q  <= 1'b0;
			enc_off_q  <= '0;
			gyro_off_q <= '0;
			angle_q    <= '0;
		end else if (req.update) begin
			src_enc_q  <= req.use_enc;
			enc_off_q  <= enc_off_nx;
			gyro_off_q <= gyro_off_nx;
			angle_q    <= angle_nx;
		end
	end

	assign angle    = angle_q;
	assign from_enc = src_enc_q;

endmodule

// ===== design/gyro_encoder_angle_estimator.sv =====
// Top level of the gimbal pitch angle estimator: control sequencer, config
// registers, still counter and integral. Depends on gea_pkg, the channel
// interfaces, gea_div and gea_src.
//
//   channel  | role   | beat carries
//   ---------+--------+---------------------------------------------------
//   sample   | sink   | pitch_rate, encoder_angle, chassis_rate, force_encoder
//   result   | source | angle_out, encoder_used
//   cfg      | sink   | index, data (always ready)
//
// One sample passes the accept step, one divider step per quotient bit, then
// divider done, integral update and result load. A waiting result holds the
// block in the load step, and no new sample is taken until the result is loaded.
// arst_n clears the state, the counters, and restores config reset values.
module gyro_encoder_angle_estimator (
	input  logic      clk,
	input  logic      arst_n,
	gea_in_if.sink    sample,
	gea_out_if.source result,
	gea_cfg_if.sink   cfg
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_INTEG = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]                         state_q;
	logic                               out_valid_q;
	logic [gea_pkg::DIV_W-1:0]          rate_div_q;
	logic [gea_pkg::THR_W-1:0]          still_thr_q;
	logic [gea_pkg::COUNT_W-1:0]        settle_q;
	logic [gea_pkg::COUNT_W-1:0]        still_q;
	logic [gea_pkg::INT_W-1:0]          integ_q;
	logic                               neg_q;
	logic                               force_q;
	logic [gea_pkg::ANGLE_W-1:0]        enc_q;

	logic                               accept;
	logic                               emit;
	logic [gea_pkg::RATE_W-1:0]         pmag;
	logic [gea_pkg::RATE_W-1:0]         cmag;
	logic [gea_pkg::ANGLE_W-1:0]        enc_red;
	logic [gea_pkg::INT_W:0]            integ_sum;
	logic [gea_pkg::INT_W-1:0]          integ_nx;
	gea_pkg::div_stat_t                 div_stat;
	logic [gea_pkg::INT_W-1:0]          qmod;
	gea_pkg::src_req_t                  src_req;

	assign sample.ready = state_q == ST_IDLE;
	assign accept       = sample.valid && sample.ready;
	assign emit         = (state_q == ST_EMIT) && (!out_valid_q || result.ready);
	assign cfg.ready    = 1'b1;

	// Magnitudes of the two rates and the encoder folded into one turn
	always_comb begin
		pmag = sample.pitch_rate[gea_pkg::RATE_W-1] ?
			(~sample.pitch_rate + 1'b1) : sample.pitch_rate;
		cmag = sample.chassis_rate[gea_pkg::RATE_W-1] ?
			(~sample.chassis_rate + 1'b1) : sample.chassis_rate;
		enc_red = (sample.encoder_angle >= gea_pkg::FULL_TURN) ?
			(sample.encoder_angle - gea_pkg::FULL_TURN) : sample.encoder_angle;
	end

	// Add or subtract the reduced increment, wrap into one turn
	always_comb begin
		if (neg_q) begin
			if (integ_q >= qmod) begin
				integ_sum = {1'b0, integ_q} - {1'b0, qmod};
			end else begin
				integ_sum = {1'b0, integ_q} + {1'b0, gea_pkg::INT_MODULUS} - {1'b0, qmod};
			end
		end else begin
			integ_sum = {1'b0, integ_q} + {1'b0, qmod};
			if (integ_sum >= {1'b0, gea_pkg::INT_MODULUS}) begin
				integ_sum = integ_sum - {1'b0, gea_pkg::INT_MODULUS};
			end
		end
		integ_nx = integ_sum[gea_pkg::INT_W-1:0];
	end

	// Sequence one sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_INTEG;
					end
				end
				ST_INTEG: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_div_q  <= gea_pkg::RST_RATE_DIVIDER;
			still_thr_q <= gea_pkg::RST_STILL_THRESHOLD;
			settle_q    <= gea_pkg::RST_SETTLE_TICKS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				gea_pkg::REG_RATE_DIVIDER:    rate_div_q  <= cfg.data[gea_pkg::DIV_W-1:0];
				gea_pkg::REG_STILL_THRESHOLD: still_thr_q <= cfg.data[gea_pkg::THR_W-1:0];
				gea_pkg::REG_SETTLE_TICKS:    settle_q    <= cfg.data[gea_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Still counter and integral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_q <= '0;
			integ_q <= '0;
		end else begin
			if (accept) begin
				if (cmag < {1'b0, still_thr_q}) begin
					if (still_q != '1) begin
						still_q <= still_q + 1'b1;
					end
				end else begin
					still_q <= '0;
				end
			end
			if (state_q == ST_INTEG) begin
				integ_q <= integ_nx;
			end
		end
	end

	// Latch the per-sample operands
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= sample.pitch_rate[gea_pkg::RATE_W-1];
			force_q <= sample.force_encoder;
			enc_q   <= enc_red;
		end
	end

	gea_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.mag     (pmag),
		.divisor (rate_div_q),
		.stat    (div_stat),
		.qmod    (qmod)
	);

	assign src_req.update    = emit;
	assign src_req.use_enc   = (still_q > settle_q) || force_q;
	assign src_req.force_enc = force_q;

	gea_src u_src (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (src_req),
		.enc      (enc_q),
		.gyro     (integ_q[gea_pkg::INT_W-1:gea_pkg::FRACTION_BITS]),
		.angle    (result.angle_out),
		.from_enc (result.encoder_used)
	);

	assign result.valid = out_valid_q;

	// A result appears only from the load step
	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
		else $error("result valid rose outside the load step");

	// The integral stays inside one turn
	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		integ_q < gea_pkg::INT_MODULUS)
		else $error("integral out of range");

	// The delivered angle stays inside one turn
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.angle_out < gea_pkg::FULL_TURN)
		else $error("angle out of range");

	// An accepted sample starts the divider
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DIV) && div_stat.busy)
		else $error("divider not started on accept");

endmodule

// ===== sim/tb_gyro_encoder_angle_estimator.sv =====
// Testbench for gyro_encoder_angle_estimator: directed and random sensor samples, each
// result checked against an in-bench estimate or its typed value. Config writes between
// phases. Depends on gea_pkg and the gea_in_if, gea_out_if and gea_cfg_if interfaces.
module tb_gyro_encoder_angle_estimator;

	localparam int FB         = gea_pkg::FRACTION_BITS;
	localparam int TURN       = gea_pkg::FULL_TURN;
	localparam int SETTLE_CYC = 22 + FB + 10;
	localparam int QUIET_MAX  = 4000;
	localparam int MAX_SHOWN  = 10;
	localparam logic [gea_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [gea_pkg::ANGLE_W-1:0] angle;
		logic                        on_enc;
	} estimate_t;

	typedef struct {
		logic signed [gea_pkg::RATE_W-1:0] pitch;
		logic [gea_pkg::ANGLE_W-1:0]       enc;
		logic signed [gea_pkg::RATE_W-1:0] chassis;
		logic                              force_enc;
		bit                                typed;
		estimate_t                         want;
	} sample_t;

	logic clk;
	logic arst_n;

	gea_in_if  smp_ch ();
	gea_out_if res_ch ();
	gea_cfg_if cfg_ch ();

	gyro_encoder_angle_estimator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Estimator state and register copies
	longint est_integral;
	int     est_still;
	bit     est_on_enc;
	int     est_enc_off;
	int     est_gyro_off;
	int     est_angle;
	int     est_div;
	int     est_thr;
	int     est_settle;

	estimate_t pending_angles[$];
	sample_t   cur_item;
	int        angle_errors;
	int        quiet_cycles;
	bit        calm;
	bit        still_run;
	bit        force_run;

	// Advance the estimate by one tick and return the angle it reports
	function automatic estimate_t advance_estimate(sample_t s);
		longint modl, pr, mag, quo, sum, cr, cmag, dv;
		int gyro_ang, enc_w;
		bit was_enc;
		estimate_t o;
		modl = longint'(TURN) << FB;
		dv = (est_div == 0) ? 1 : est_div;
		pr = s.pitch;
		mag = (pr < 0) ? -pr : pr;
		quo = (mag << FB) / dv;
		sum = est_integral + ((pr < 0) ? -quo : quo);
		sum = sum % modl;
		if (sum < 0) begin
			sum = sum + modl;
		end
		est_integral = sum;
		gyro_ang = int'((est_integral >> FB) % TURN);

		cr = s.chassis;
		cmag = (cr < 0) ? -cr : cr;
		if (cmag < est_thr) begin
			if (est_still < 16'hFFFF) begin
				est_still++;
			end
		end else begin
			est_still = 0;
		end

		enc_w = int'(s.enc) % TURN;
		was_enc = est_on_enc;
		if (est_still > est_settle || s.force_enc) begin
			est_on_enc = 1'b1;
			if (!was_enc) begin
				est_enc_off = (est_angle + TURN - enc_w) % TURN;
			end
			if (s.force_enc) begin
				est_enc_off = 0;
			end
			est_angle = (enc_w + est_enc_off) % TURN;
		end else begin
			est_on_enc = 1'b0;
			if (was_enc) begin
				est_gyro_off = (est_angle + TURN - gyro_ang) % TURN;
			end
			est_angle = (gyro_ang + est_gyro_off) % TURN;
		end
		o.angle = gea_pkg::ANGLE_W'(est_angle);
		o.on_enc = est_on_enc;
		return o;
	endfunction

	function automatic sample_t row(int pitch, int enc, int chassis, bit fe,
			bit typed = 1'b0, int angle = 0, bit on_enc = 1'b0);
		sample_t s;
		s.pitch = gea_pkg::RATE_W'(pitch);
		s.enc = gea_pkg::ANGLE_W'(enc);
		s.chassis = gea_pkg::RATE_W'(chassis);
		s.force_enc = fe;
		s.typed = typed;
		s.want.angle = gea_pkg::ANGLE_W'(angle);
		s.want.on_enc = on_enc;
		return s;
	endfunction

	// Random tick: still and forced stretches with random content, some raw noise
	function automatic sample_t roll_sample();
		sample_t s;
		int pick, lim, mag;
		pick = int'($urandom_range(99));
		if (pick < 8) begin
			s.pitch = gea_pkg::RATE_W'($urandom);
		end else if (pick < 14) begin
			s.pitch = $urandom_range(1) ? 18'h1FFFF : 18'h20000;
		end else begin
			s.pitch = gea_pkg::RATE_W'(int'($urandom_range(6000)) - 3000);
		end
		s.enc = ($urandom_range(99) < 8) ? gea_pkg::ANGLE_W'($urandom_range(32767, TURN)) :
			gea_pkg::ANGLE_W'($urandom_range(TURN - 1));
		if ($urandom_range(99) < 6) begin
			still_run = !still_run;
		end
		if (still_run && $urandom_range(99) < 95) begin
			lim = (est_thr > 0) ? est_thr - 1 : 0;
			if (lim > 131071) begin
				lim = 131071;
			end
			mag = int'($urandom_range(lim));
			s.chassis = $urandom_range(1) ? gea_pkg::RATE_W'(-mag) : gea_pkg::RATE_W'(mag);
		end else begin
			s.chassis = gea_pkg::RATE_W'($urandom);
		end
		if ($urandom_range(99) < 4) begin
			force_run = !force_run;
		end
		s.force_enc = force_run;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	// Offer one sample beat, idling at random unless calm, and hold it until taken
	task automatic push_sample(input sample_t s);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 18) begin
			smp_ch.valid = 1'b0;
			@(negedge clk);
		end
		cur_item = s;
		smp_ch.pitch_rate = s.pitch;
		smp_ch.encoder_angle = s.enc;
		smp_ch.chassis_rate = s.chassis;
		smp_ch.force_encoder = s.force_enc;
		smp_ch.valid = 1'b1;
		do @(posedge clk); while (!smp_ch.ready);
	endtask

	task automatic write_reg(input logic [gea_pkg::CFG_IDX_W-1:0] idx,
			input logic [gea_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.index = idx;
		cfg_ch.data = val;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Drop valid, wait out every pending estimate, then let the block settle
	task automatic drain();
		@(negedge clk);
		smp_ch.valid = 1'b0;
		while (pending_angles.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result back-pressure
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready = calm || ($urandom_range(99) >= 18);
		end
	end

	// Check result beats, predict on sample beats, track register writes
	always @(posedge clk) begin : monitor
		estimate_t want, got;
		if (arst_n) begin
			quiet_cycles = quiet_cycles + 1;
			if (res_ch.valid && res_ch.ready) begin
				quiet_cycles = 0;
				got.angle = res_ch.angle_out;
				got.on_enc = res_ch.encoder_used;
				if (pending_angles.size() == 0) begin
					angle_errors++;
					if (angle_errors <= MAX_SHOWN) begin
						$display("unexpected result: angle %0d encoder_used %0b",
							got.angle, got.on_enc);
					end
				end else begin
					want = pending_angles.pop_front();
					if (got.angle !== want.angle || got.on_enc !== want.on_enc) begin
						angle_errors++;
						if (angle_errors <= MAX_SHOWN) begin
							$display("mismatch: expected %0d/%0b, got %0d/%0b (angle/enc)",
								want.angle, want.on_enc, got.angle, got.on_enc);
						end
					end
				end
			end
			if (smp_ch.valid && smp_ch.ready) begin
				quiet_cycles = 0;
				want = advance_estimate(cur_item);
				if (cur_item.typed) begin
					want = cur_item.want;
				end
				pending_angles.push_back(want);
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				quiet_cycles = 0;
				case (cfg_ch.index)
					gea_pkg::REG_RATE_DIVIDER: begin
						est_div = int'(cfg_ch.data[gea_pkg::DIV_W-1:0]);
					end
					gea_pkg::REG_STILL_THRESHOLD: begin
						est_thr = int'(cfg_ch.data[gea_pkg::THR_W-1:0]);
					end
					gea_pkg::REG_SETTLE_TICKS: begin
						est_settle = int'(cfg_ch.data[gea_pkg::COUNT_W-1:0]);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	initial begin
		while (quiet_cycles < QUIET_MAX) begin
			@(posedge clk);
		end
		$display("tb_gyro_encoder_angle_estimator: FAIL");
		$finish;
	end

	initial begin
		sample_t directed[$];
		int ph_div[6];
		int ph_thr[6];
		int ph_settle[6];

		ph_div    = '{1000, 100, 10000, 0, 17'h1FFFF, 357};
		ph_thr    = '{192, 128000, 0, 500, 131071, 2000};
		ph_settle = '{400, 0, 65535, 5, 17'h10003, 20};

		// Hold every input at a known value through reset
		arst_n = 1'b0;
		smp_ch.valid = 1'b0;
		smp_ch.pitch_rate = '0;
		smp_ch.encoder_angle = '0;
		smp_ch.chassis_rate = '0;
		smp_ch.force_encoder = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = gea_pkg::REG_RATE_DIVIDER;
		cfg_ch.data = '0;
		cur_item = row(0, 0, 0, 1'b0);
		calm = 1'b0;
		still_run = 1'b1;
		force_run = 1'b0;
		angle_errors = 0;
		quiet_cycles = 0;
		est_integral = 0;
		est_still = 0;
		est_on_enc = 1'b0;
		est_enc_off = 0;
		est_gyro_off = 0;
		est_angle = 0;
		est_div = int'(gea_pkg::RST_RATE_DIVIDER);
		est_thr = int'(gea_pkg::RST_STILL_THRESHOLD);
		est_settle = int'(gea_pkg::RST_SETTLE_TICKS);

		// Reset-value rows first: zero rate, forced encoder, out-of-range encoder
		directed.push_back(row(0, 0, 0, 1'b0, 1'b1, 0, 1'b0));
		directed.push_back(row(0, TURN - 1, 0, 1'b1, 1'b1, TURN - 1, 1'b1));
		directed.push_back(row(0, 32767, 5, 1'b1, 1'b1, 32767 - TURN, 1'b1));
		// Leaving the encoder keeps the angle where it was
		directed.push_back(row(131071, 100, -131072, 1'b0, 1'b1, 32767 - TURN, 1'b0));
		directed.push_back(row(-131072, 0, 131071, 1'b0));
		directed.push_back(row(1, 23039, 191, 1'b0));
		directed.push_back(row(-1, 1, 192, 1'b0));
		directed.push_back(row(0, 12345, -191, 1'b0));
		directed.push_back(row(131071, 200, -192, 1'b0));
		directed.push_back(row(131071, 300, 0, 1'b0));
		directed.push_back(row(0, TURN, 0, 1'b1, 1'b1, 0, 1'b1));
		directed.push_back(row(-5000, 0, 0, 1'b1, 1'b1, 0, 1'b1));
		directed.push_back(row(999, 4000, 0, 1'b0, 1'b1, 0, 1'b0));
		directed.push_back(row(-131072, 16384, -1, 1'b0));
		directed.push_back(row(-131072, 8191, 1, 1'b0));
		directed.push_back(row(65535, 32767, 65536, 1'b0));
		directed.push_back(row(-65536, 5000, -65536, 1'b1));
		directed.push_back(row(-65536, 6000, 10, 1'b1));
		directed.push_back(row(777, 7000, 10, 1'b0));
		directed.push_back(row(-777, 22000, 100, 1'b0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			push_sample(directed[i]);
		end

		// Random phases, each under its own register setting
		for (int p = 0; p < 6; p++) begin
			drain();
			if (p == 3) begin
				write_reg(REG_UNUSED, gea_pkg::CFG_DATA_W'($urandom));
			end
			write_reg(gea_pkg::REG_RATE_DIVIDER, gea_pkg::CFG_DATA_W'(ph_div[p]));
			write_reg(gea_pkg::REG_STILL_THRESHOLD, gea_pkg::CFG_DATA_W'(ph_thr[p]));
			write_reg(gea_pkg::REG_SETTLE_TICKS, gea_pkg::CFG_DATA_W'(ph_settle[p]));
			calm = (p == 2);
			for (int n = 0; n < 100; n++) begin
				push_sample(roll_sample());
			end
		end
		calm = 1'b0;
		drain();

		if (pending_angles.size() != 0) begin
			angle_errors++;
		end
		if (angle_errors == 0) begin
			$display("tb_gyro_encoder_angle_estimator: PASS");
		end else begin
			$display("tb_gyro_encoder_angle_estimator: FAIL");
		end
		$finish;
	end

endmodule
